### rtl/lpaa_pkg.sv
// shared constants, types and the arctangent table for the line pair angle unit
package lpaa_pkg;

  localparam int SLOPE_W     = 32;
  localparam int ANGLE_W     = 16;
  localparam int FRAC_SHIFT  = 16;
  localparam int SHRINK_W    = 18;
  localparam int SCALE_LIMIT = 131072;
  localparam int CORDIC_W    = 40;
  localparam int Z_W         = 34;
  localparam int ROUND_HALF  = 16384;
  localparam int ANGLE_SHIFT = 15;
  localparam int HALF_PI_Q15 = 51472;
  localparam int ATAN_LEN    = 24;

  // special cases that bypass the cordic result
  typedef struct packed {
    logic perp;
    logic cross_zero;
    logic dot_zero;
  } angle_flags_t;

  // atan(2^-i) in q30
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd843314857;
      5'd1:  r = 32'd497837829;
      5'd2:  r = 32'd263043837;
      5'd3:  r = 32'd133525159;
      5'd4:  r = 32'd67021687;
      5'd5:  r = 32'd33543516;
      5'd6:  r = 32'd16775851;
      5'd7:  r = 32'd8388437;
      5'd8:  r = 32'd4194283;
      5'd9:  r = 32'd2097149;
      5'd10: r = 32'd1048576;
      5'd11: r = 32'd524288;
      5'd12: r = 32'd262144;
      5'd13: r = 32'd131072;
      5'd14: r = 32'd65536;
      5'd15: r = 32'd32768;
      5'd16: r = 32'd16384;
      5'd17: r = 32'd8192;
      5'd18: r = 32'd4096;
      5'd19: r = 32'd2048;
      5'd20: r = 32'd1024;
      5'd21: r = 32'd512;
      5'd22: r = 32'd256;
      5'd23: r = 32'd128;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/line_pair_acute_angle_unit.sv
// top level of the line pair acute angle unit: slopes, vertical flags and acute angle
//
//  channel   signals                                  beat taken when
//  --------  ---------------------------------------  ----------------------------
//  input     start_i, busy_o, eight endpoint coords   start_i high and busy_o low
//  result    done_o, slopes, vertical flags, angle,   done_o high, one cycle only
//            perpendicular flag
//
// fully pipelined: one beat enters per cycle, busy_o never rises
// the shorter of the bit-per-stage divider path and the angle path is padded to match
// reset clears only the valid bits; payload registers carry no reset
// the receiver cannot stall, so no back-pressure exists anywhere in the pipe
module line_pair_acute_angle_unit #(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [COORD_WIDTH-1:0]         first_x_start_i,
  input  logic signed [COORD_WIDTH-1:0]         first_y_start_i,
  input  logic signed [COORD_WIDTH-1:0]         first_x_end_i,
  input  logic signed [COORD_WIDTH-1:0]         first_y_end_i,
  input  logic signed [COORD_WIDTH-1:0]         second_x_start_i,
  input  logic signed [COORD_WIDTH-1:0]         second_y_start_i,
  input  logic signed [COORD_WIDTH-1:0]         second_x_end_i,
  input  logic signed [COORD_WIDTH-1:0]         second_y_end_i,
  output logic                                  done_o,
  output logic signed [lpaa_pkg::SLOPE_W-1:0]   first_slope_o,
  output logic                                  first_vertical_o,
  output logic signed [lpaa_pkg::SLOPE_W-1:0]   second_slope_o,
  output logic                                  second_vertical_o,
  output logic [lpaa_pkg::ANGLE_W-1:0]          acute_angle_o,
  output logic                                  perpendicular_o
);
  import lpaa_pkg::*;

  localparam int XW      = COORD_WIDTH + 1;
  localparam int LAT_DIV = XW + FRAC_SHIFT + 2;
  localparam int LAT_ANG = CORDIC_STEPS + 5;
  localparam int LAT_MAX = (LAT_DIV > LAT_ANG) ? LAT_DIV : LAT_ANG;
  localparam int SLW     = 2 * (SLOPE_W + 1);
  localparam int ANW     = ANGLE_W + 1;

  logic accept;

  // no stall source downstream, so the unit is always ready
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // stage 1: direction vectors, one bit wider than the coordinates
  logic                 vld1_q;
  logic signed [XW-1:0] dx1_q, dy1_q, dx2_q, dy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q <= XW'(first_x_end_i) - XW'(first_x_start_i);
    dy1_q <= XW'(first_y_end_i) - XW'(first_y_start_i);
    dx2_q <= XW'(second_x_end_i) - XW'(second_x_start_i);
    dy2_q <= XW'(second_y_end_i) - XW'(second_y_start_i);
  end

  // slope dividers, one per line
  logic                      dv1_vld, dv2_vld;
  logic signed [SLOPE_W-1:0] dv1_slope, dv2_slope;
  logic                      dv1_vert, dv2_vert;

  lpaa_divider #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_div_first (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld1_q),
    .dx_i       (dx1_q),
    .dy_i       (dy1_q),
    .valid_o    (dv1_vld),
    .slope_o    (dv1_slope),
    .vertical_o (dv1_vert)
  );

  lpaa_divider #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_div_second (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld1_q),
    .dx_i       (dx2_q),
    .dy_i       (dy2_q),
    .valid_o    (dv2_vld),
    .slope_o    (dv2_slope),
    .vertical_o (dv2_vert)
  );

  // angle path
  logic               an_vld;
  logic [ANGLE_W-1:0] an_angle;
  logic               an_perp;

  lpaa_angle #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld1_q),
    .dx1_i   (dx1_q),
    .dy1_i   (dy1_q),
    .dx2_i   (dx2_q),
    .dy2_i   (dy2_q),
    .valid_o (an_vld),
    .angle_o (an_angle),
    .perp_o  (an_perp)
  );

  // pad the shorter path so both halves of a result land together
  logic           sl_vld, ag_vld;
  logic [SLW-1:0] sl_data;
  logic [ANW-1:0] ag_data;

  lpaa_delay #(
    .DEPTH (LAT_MAX - LAT_DIV),
    .WIDTH (SLW)
  ) u_pad_slope (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv1_vld & dv2_vld),
    .data_i  ({dv1_slope, dv1_vert, dv2_slope, dv2_vert}),
    .valid_o (sl_vld),
    .data_o  (sl_data)
  );

  lpaa_delay #(
    .DEPTH (LAT_MAX - LAT_ANG),
    .WIDTH (ANW)
  ) u_pad_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (an_vld),
    .data_i  ({an_angle, an_perp}),
    .valid_o (ag_vld),
    .data_o  (ag_data)
  );

  // result beat
  assign done_o            = sl_vld & ag_vld;
  assign first_slope_o     = $signed(sl_data[SLW-1 -: SLOPE_W]);
  assign first_vertical_o  = sl_data[SLOPE_W + 1];
  assign second_slope_o    = $signed(sl_data[SLOPE_W:1]);
  assign second_vertical_o = sl_data[0];
  assign acute_angle_o     = ag_data[ANW-1:1];
  assign perpendicular_o   = ag_data[0];

endmodule

### rtl/lpaa_delay.sv
// fixed-length register delay line with a valid bit
module lpaa_delay #(
  parameter int DEPTH = 1,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  if (DEPTH == 0) begin : g_none
    assign valid_o = valid_i;
    assign data_o  = data_i;
  end else begin : g_line
    logic             vld_q  [DEPTH];
    logic [WIDTH-1:0] data_q [DEPTH];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
      end else begin
        vld_q[0] <= valid_i;
        for (int i = 1; i < DEPTH; i++) vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      data_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) data_q[i] <= data_q[i-1];
    end

    assign valid_o = vld_q[DEPTH-1];
    assign data_o  = data_q[DEPTH-1];
  end

endmodule

### rtl/lpaa_divider.sv
// pipelined restoring divider for one slope, one quotient bit per stage, with saturation
module lpaa_divider #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [COORD_WIDTH:0]       dx_i,
  input  logic signed [COORD_WIDTH:0]       dy_i,
  output logic                              valid_o,
  output logic signed [lpaa_pkg::SLOPE_W-1:0] slope_o,
  output logic                              vertical_o
);
  import lpaa_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int NW = DW + FRAC_SHIFT;
  localparam int QW = (NW > SLOPE_W + 1) ? NW : SLOPE_W + 1;
  localparam logic [QW-1:0] POS_MAX = QW'(64'h7FFF_FFFF);
  localparam logic [QW-1:0] NEG_MAX = QW'(64'h8000_0000);

  logic          vld_q  [NW+1];
  logic [DW-1:0] rem_q  [NW+1];
  logic [NW-1:0] nq_q   [NW+1];
  logic [DW-1:0] den_q  [NW+1];
  logic          neg_q  [NW+1];
  logic          zero_q [NW+1];

  logic [DW-1:0] mag_dx, mag_dy;

  assign mag_dx = dx_i[COORD_WIDTH] ? (~dx_i + 1'b1) : dx_i;
  assign mag_dy = dy_i[COORD_WIDTH] ? (~dy_i + 1'b1) : dy_i;

  // operand prep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    nq_q[0]   <= {mag_dy, {FRAC_SHIFT{1'b0}}};
    den_q[0]  <= mag_dx;
    neg_q[0]  <= dx_i[COORD_WIDTH] ^ dy_i[COORD_WIDTH];
    zero_q[0] <= (dx_i == '0);
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_q[k], nq_q[k][NW-1]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign ge    = (trial >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      nq_q[k+1]   <= {nq_q[k][NW-2:0], ge};
      den_q[k+1]  <= den_q[k];
      neg_q[k+1]  <= neg_q[k];
      zero_q[k+1] <= zero_q[k];
    end
  end

  // saturate and apply sign; a vertical line gives a zero slope
  logic [QW-1:0]      quo;
  logic [QW-1:0]      quo_sat;
  logic [SLOPE_W-1:0] slope_d;
  logic               vld_out_q;
  logic [SLOPE_W-1:0] slope_q;
  logic               vert_q;

  assign quo = QW'(nq_q[NW]);

  always_comb begin
    if (neg_q[NW]) begin
      quo_sat = (quo > NEG_MAX) ? NEG_MAX : quo;
      slope_d = SLOPE_W'(~quo_sat + 1'b1);
    end else begin
      quo_sat = (quo > POS_MAX) ? POS_MAX : quo;
      slope_d = quo_sat[SLOPE_W-1:0];
    end
    if (zero_q[NW]) slope_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    slope_q <= slope_d;
    vert_q  <= zero_q[NW];
  end

  assign valid_o    = vld_out_q;
  assign slope_o    = $signed(slope_q);
  assign vertical_o = vert_q;

endmodule

### rtl/lpaa_cordic.sv
// pipelined vectoring cordic arctangent, one iteration per stage, rounded to q1.15
module lpaa_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [lpaa_pkg::CORDIC_W-1:0] x_i,
  input  logic signed [lpaa_pkg::CORDIC_W-1:0] y_i,
  input  lpaa_pkg::angle_flags_t               flags_i,
  output logic                                 valid_o,
  output logic [lpaa_pkg::ANGLE_W-1:0]         angle_o,
  output logic                                 perp_o
);
  import lpaa_pkg::*;

  logic                       vld_q [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_q   [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_q   [CORDIC_STEPS];
  logic signed [Z_W-1:0]      z_q   [CORDIC_STEPS];
  angle_flags_t               fl_q  [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    logic                       vin;
    logic signed [CORDIC_W-1:0] xin, yin, xs, ys;
    logic signed [Z_W-1:0]      zin, step;
    angle_flags_t               fin;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign xin = x_i;
      assign yin = y_i;
      assign zin = '0;
      assign fin = flags_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign xin = x_q[k-1];
      assign yin = y_q[k-1];
      assign zin = z_q[k-1];
      assign fin = fl_q[k-1];
    end

    assign xs   = xin >>> k;
    assign ys   = yin >>> k;
    assign step = $signed(Z_W'(atan_q30(5'(k))));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!yin[CORDIC_W-1]) begin
        x_q[k] <= xin + ys;
        y_q[k] <= yin - xs;
        z_q[k] <= zin + step;
      end else begin
        x_q[k] <= xin - ys;
        y_q[k] <= yin + xs;
        z_q[k] <= zin - step;
      end
      fl_q[k] <= fin;
    end
  end

  // round half up, clamp, then the special cases
  localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(HALF_PI_Q15);

  logic signed [Z_W-1:0] z_rnd;
  logic [ANGLE_W-1:0]    angle_d;
  angle_flags_t          fl_last;
  logic                  vld_out_q;
  logic [ANGLE_W-1:0]    angle_q;
  logic                  perp_q;

  assign z_rnd   = (z_q[CORDIC_STEPS-1] + Z_W'(ROUND_HALF)) >>> ANGLE_SHIFT;
  assign fl_last = fl_q[CORDIC_STEPS-1];

  always_comb begin
    if (z_rnd < 0) begin
      angle_d = '0;
    end else if (z_rnd > HALF_PI_Z) begin
      angle_d = ANGLE_W'(HALF_PI_Q15);
    end else begin
      angle_d = z_rnd[ANGLE_W-1:0];
    end
    if (fl_last.perp) begin
      angle_d = ANGLE_W'(HALF_PI_Q15);
    end else if (fl_last.cross_zero) begin
      angle_d = '0;
    end else if (fl_last.dot_zero) begin
      angle_d = ANGLE_W'(HALF_PI_Q15);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    perp_q  <= fl_last.perp;
  end

  assign valid_o = vld_out_q;
  assign angle_o = angle_q;
  assign perp_o  = perp_q;

endmodule

### rtl/lpaa_angle.sv
// angle front end: perpendicular test, range shrink, cross and dot products, then cordic
module lpaa_angle #(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH:0]   dx1_i,
  input  logic signed [COORD_WIDTH:0]   dy1_i,
  input  logic signed [COORD_WIDTH:0]   dx2_i,
  input  logic signed [COORD_WIDTH:0]   dy2_i,
  output logic                          valid_o,
  output logic [lpaa_pkg::ANGLE_W-1:0]  angle_o,
  output logic                          perp_o
);
  import lpaa_pkg::*;

  localparam int XW     = COORD_WIDTH + 1;
  localparam int PW     = 2 * XW;
  localparam int WD     = XW + 20;
  localparam int SH_MAX = (COORD_WIDTH > 16) ? COORD_WIDTH - 16 : 0;
  localparam int SHW    = (SH_MAX < 1) ? 1 : $clog2(SH_MAX + 1);
  localparam int SPW    = 2 * SHRINK_W;
  localparam logic signed [WD-1:0] LIM  = WD'(SCALE_LIMIT);
  localparam logic signed [WD-1:0] NLIM = -LIM;

  // number of floor halvings until both magnitudes drop below the limit
  function automatic logic [SHW-1:0] shrink_count(input logic signed [XW-1:0] a,
                                                  input logic signed [XW-1:0] b);
    logic signed [WD-1:0] aw, bw, as, bs;
    logic [SHW-1:0]       c;
    aw = WD'(a);
    bw = WD'(b);
    c  = '0;
    for (int s = 0; s < SH_MAX; s++) begin
      as = aw >>> s;
      bs = bw >>> s;
      if (!(as > NLIM && as < LIM && bs > NLIM && bs < LIM)) c = SHW'(s + 1);
    end
    return c;
  endfunction

  function automatic logic signed [SHRINK_W-1:0] shrink_val(input logic signed [XW-1:0] a,
                                                            input logic [SHW-1:0] c);
    logic signed [WD-1:0] aw;
    aw = WD'(a);
    aw = aw >>> c;
    return aw[SHRINK_W-1:0];
  endfunction

  // stage a1: vertical substitution, exact dot partials, shrink counts
  logic signed [XW-1:0] ax1, ay1, ax2, ay2;
  logic                 v1_q;
  logic signed [PW-1:0] pxx_q, pyy_q;
  logic signed [XW-1:0] ax1_q, ay1_q, ax2_q, ay2_q;
  logic [SHW-1:0]       sh1_q, sh2_q;

  assign ax1 = dx1_i;
  assign ay1 = (dx1_i == '0) ? XW'(1) : dy1_i;
  assign ax2 = dx2_i;
  assign ay2 = (dx2_i == '0) ? XW'(1) : dy2_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pxx_q <= ax1 * ax2;
    pyy_q <= ay1 * ay2;
    ax1_q <= ax1;
    ay1_q <= ay1;
    ax2_q <= ax2;
    ay2_q <= ay2;
    sh1_q <= shrink_count(ax1, ay1);
    sh2_q <= shrink_count(ax2, ay2);
  end

  // stage a2: exact perpendicular test, shrunk vectors
  logic signed [PW:0]         dot_full;
  logic                       v2_q, perp2_q;
  logic signed [SHRINK_W-1:0] sx1_q, sy1_q, sx2_q, sy2_q;

  assign dot_full = (PW+1)'(pxx_q) + (PW+1)'(pyy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    perp2_q <= (dot_full == '0);
    sx1_q   <= shrink_val(ax1_q, sh1_q);
    sy1_q   <= shrink_val(ay1_q, sh1_q);
    sx2_q   <= shrink_val(ax2_q, sh2_q);
    sy2_q   <= shrink_val(ay2_q, sh2_q);
  end

  // stage a3: cross and dot partial products
  logic                  v3_q, perp3_q;
  logic signed [SPW-1:0] ca_q, cb_q, da_q, db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    perp3_q <= perp2_q;
    ca_q    <= sx1_q * sy2_q;
    cb_q    <= sy1_q * sx2_q;
    da_q    <= sx1_q * sx2_q;
    db_q    <= sy1_q * sy2_q;
  end

  // stage a4: sums, special-case flags, magnitudes into the cordic
  logic signed [SPW:0]        cross_s, dot_s;
  logic signed [CORDIC_W-1:0] cross_w, dot_w;
  logic                       v4_q;
  logic signed [CORDIC_W-1:0] x4_q, y4_q;
  angle_flags_t               fl4_q;

  assign cross_s = (SPW+1)'(ca_q) - (SPW+1)'(cb_q);
  assign dot_s   = (SPW+1)'(da_q) + (SPW+1)'(db_q);
  assign cross_w = CORDIC_W'(cross_s);
  assign dot_w   = CORDIC_W'(dot_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x4_q             <= dot_w[CORDIC_W-1] ? -dot_w : dot_w;
    y4_q             <= cross_w[CORDIC_W-1] ? -cross_w : cross_w;
    fl4_q.perp       <= perp3_q;
    fl4_q.cross_zero <= (cross_s == '0);
    fl4_q.dot_zero   <= (dot_s == '0);
  end

  lpaa_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .x_i     (x4_q),
    .y_i     (y4_q),
    .flags_i (fl4_q),
    .valid_o (valid_o),
    .angle_o (angle_o),
    .perp_o  (perp_o)
  );

endmodule

### rtl/lpaa_checker.sv
// port-level checker for the line pair acute angle unit and its bind
module lpaa_checker #(
  parameter int COORD_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic                                done_o,
  input logic signed [lpaa_pkg::SLOPE_W-1:0] first_slope_o,
  input logic                                first_vertical_o,
  input logic signed [lpaa_pkg::SLOPE_W-1:0] second_slope_o,
  input logic                                second_vertical_o,
  input logic [lpaa_pkg::ANGLE_W-1:0]        acute_angle_o,
  input logic                                perpendicular_o
);
  import lpaa_pkg::*;

  localparam int LAT_DIV = COORD_WIDTH + 1 + FRAC_SHIFT + 2;
  localparam int LAT_ANG = CORDIC_STEPS + 5;
  localparam int LAT     = 1 + ((LAT_DIV > LAT_ANG) ? LAT_DIV : LAT_ANG);

  // every accepted beat yields exactly one result after the fixed latency
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without an accepted beat");

  a_perp_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && perpendicular_o) |-> (acute_angle_o == ANGLE_W'(HALF_PI_Q15)))
    else $error("perpendicular result without a right angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (acute_angle_o <= ANGLE_W'(HALF_PI_Q15)))
    else $error("angle above pi/2");

  a_vert_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (first_vertical_o || second_vertical_o)) |->
      ((!first_vertical_o || first_slope_o == '0) &&
       (!second_vertical_o || second_slope_o == '0)))
    else $error("vertical line with nonzero slope");

endmodule

bind line_pair_acute_angle_unit lpaa_checker #(
  .COORD_WIDTH  (COORD_WIDTH),
  .CORDIC_STEPS (CORDIC_STEPS)
) u_lpaa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .first_slope_o     (first_slope_o),
  .first_vertical_o  (first_vertical_o),
  .second_slope_o    (second_slope_o),
  .second_vertical_o (second_vertical_o),
  .acute_angle_o     (acute_angle_o),
  .perpendicular_o   (perpendicular_o)
);
